[sv/vdwr_pkg.sv]
// Package for the dirty-window display refresh block.
// Holds sizes, state and code enums and a small helper function.
// No dependencies.
package vdwr_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_BYTE_ROWS = 8;
  localparam int STORE_DEPTH   = MAX_COLUMNS * MAX_BYTE_ROWS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int COL_W         = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W        = $clog2(MAX_BYTE_ROWS + 1);
  localparam int IDX_W         = 4 + COL_W;

  localparam logic [7:0] WINDOW_CMD = 8'hF1;
  localparam logic [7:0] WINDOW_END = 8'h76;
  localparam logic [7:0] BRIGHT_CMD = 8'h30;
  localparam logic [2:0] HDR_DONE   = 3'd6;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_PIXEL  = 3'd1,
    MODE_EIGHT  = 3'd2,
    MODE_REFR   = 3'd3,
    MODE_PULL   = 3'd4,
    MODE_BRIGHT = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_UPSIDE = 3'd2,
    CFG_INVERT = 3'd3,
    CFG_PERIOD = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_PIX,
    S_PIX_WR,
    S_WALK,
    S_MOD,
    S_FIN,
    S_PULL_RD,
    S_PULL_DAT
  } state_e;

  // Brightness code sent after the command byte.
  function automatic logic [1:0] bright_code(input logic [7:0] pct);
    logic [1:0] code;
    if (pct >= 8'd100)     code = 2'd0;
    else if (pct >= 8'd75) code = 2'd1;
    else if (pct >= 8'd50) code = 2'd2;
    else                   code = 2'd3;
    return code;
  endfunction

endpackage

[sv/vdwr_store.sv]
// Byte store with one write port and one registered read port.
// Depends on vdwr_pkg for the store size.
module vdwr_store import vdwr_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [STORE_DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[sv/vfd_dirty_window_refresh.sv]
// Top level of the dirty-window display refresh block.
// Depends on vdwr_pkg and vdwr_store (drawing and shadow stores).
//
//  channel | signals                                         | direction
//  input   | in_valid_i, in_stall_o, mode_i .. percent_i     | in
//  output  | out_valid_o, out_stall_i, is_data_o .. last_o  | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// After reset a clearing pass zeroes both stores; no item is
// taken meanwhile. Clear zeroes the drawing store only; set pixel and set
// eight pixels do a drawing store read-modify-write per lit pixel.
// Refresh walks both stores, then takes remainder steps on the refresh
// count. Pull of a data byte reads the shadow store. Input stalls while
// a result waits or while a command is in progress.
module vfd_dirty_window_refresh import vdwr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] pos_x_i,
  input  logic [5:0] pos_y_i,
  input  logic [7:0] pixel_bits_i,
  input  logic       force_full_i,
  input  logic [7:0] percent_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [8:0] width_q;
  logic [6:0] height_q;
  logic       upside_q, invert_q;
  logic [7:0] period_q;

  // Transfer state.
  logic [7:0]        rcount_q;
  logic [COL_W-1:0]  win_min_col_q;
  logic [7:0]        win_max_col_q;
  logic [ROWS_W-1:0] win_min_row_q, win_max_row_q;
  logic [7:0]        send_col_q;
  logic [3:0]        send_row_q;
  logic [2:0]        hdr_q;
  logic              busy_q;

  // Sequencer working registers.
  logic [ADDR_W-1:0] sweep_q;
  logic [ADDR_W:0]   widx_q;
  logic [COL_W-1:0]  wx_q, x1_q;
  logic [ROWS_W-1:0] wr_q, r1_q;
  logic              v1_q;
  logic [ADDR_W-1:0] a1_q;
  logic [COL_W-1:0]  min_x_q, max_x_q;
  logic [ROWS_W-1:0] min_r_q, max_r_q;
  logic              dirty_q, force_q;
  logic [8:0]        modv_q;
  logic [COL_W-1:0]  pbase_q;
  logic [5:0]        py_q;
  logic [7:0]        pbits_q;
  logic [2:0]        n_q;
  logic [ADDR_W-1:0] paddr_q;
  logic [7:0]        pmask_q;
  logic              prange_q;
  logic [ADDR_W-1:0] pidx_q;

  // Output register with a second pending byte for brightness.
  logic       out_vld_q, out_data_q, out_last_q, pend_q;
  logic [7:0] out_byte_q;
  logic [1:0] pend_lvl_q;

  // Store ports.
  logic              d_we, d_re, s_we, s_re;
  logic [ADDR_W-1:0] d_waddr, d_raddr, s_waddr, s_raddr;
  logic [7:0]        d_wdata, s_wdata, d_rdata, s_rdata;

  // Effective geometry.
  logic [COL_W-1:0]  w_eff;
  logic [6:0]        h_eff;
  logic [ROWS_W-1:0] rows;
  logic [COL_W-1:0]  w_m1;
  logic [8:0]        per_eff;

  always_comb begin
    if (width_q == '0) w_eff = COL_W'(1);
    else if (width_q > 9'(MAX_COLUMNS)) w_eff = COL_W'(MAX_COLUMNS);
    else w_eff = COL_W'(width_q);
    if (height_q == '0) h_eff = 7'd1;
    else if (height_q > 7'(MAX_BYTE_ROWS * 8)) h_eff = 7'(MAX_BYTE_ROWS * 8);
    else h_eff = height_q;
    rows    = ROWS_W'((8'(h_eff) + 8'd7) >> 3);
    w_m1    = w_eff - COL_W'(1);
    per_eff = (period_q == '0) ? 9'd256 : {1'b0, period_q};
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_vld_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Pixel address of the current bit of a drawing item.
  logic [COL_W-1:0]  px_x, px_xm;
  logic [6:0]        px_ym;
  logic              px_bit, px_inb, px_do;
  logic [IDX_W-1:0]  px_idx;
  always_comb begin
    px_x   = pbase_q + COL_W'(n_q);
    px_bit = pbits_q[3'd7 - n_q];
    px_inb = (px_x < w_eff) && (7'(py_q) < h_eff);
    px_xm  = upside_q ? (w_m1 - px_x) : px_x;
    px_ym  = upside_q ? (h_eff - 7'd1 - 7'(py_q)) : 7'(py_q);
    px_idx = IDX_W'(px_xm) + IDX_W'(px_ym[6:3]) * IDX_W'(w_eff);
    px_do  = px_bit && px_inb;
  end

  // Walk issue and compare.
  logic walk_iss, walk_diff;
  assign walk_iss  = wr_q < rows;
  assign walk_diff = v1_q && (d_rdata != s_rdata);

  // Pull data address and end test.
  logic [IDX_W-1:0]  pull_idx;
  logic [ROWS_W-1:0] last_row;
  logic              pull_fin;
  always_comb begin
    pull_idx = IDX_W'(send_col_q) + IDX_W'(send_row_q) * IDX_W'(w_eff);
    last_row = (win_max_row_q < rows) ? win_max_row_q : rows - ROWS_W'(1);
    pull_fin = (send_col_q >= win_max_col_q) && (send_row_q >= 4'(last_row));
  end

  // Header byte for the current header step.
  logic [7:0] hdr_byte;
  always_comb begin
    case (hdr_q)
      3'd0:    hdr_byte = WINDOW_CMD;
      3'd1:    hdr_byte = win_min_col_q[7:0];
      3'd2:    hdr_byte = 8'({win_min_row_q, 3'b000}) & 8'hF8;
      3'd3:    hdr_byte = win_max_col_q;
      3'd4:    hdr_byte = 8'({win_max_row_q, 3'b000});
      default: hdr_byte = WINDOW_END;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        if (sweep_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            MODE_CLEAR:             state_d = S_CLEAR;
            MODE_PIXEL, MODE_EIGHT: state_d = S_PIX;
            MODE_REFR:              state_d = S_WALK;
            MODE_PULL: begin
              if (busy_q && hdr_q == HDR_DONE) state_d = S_PULL_RD;
            end
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_PIX: begin
        if (px_do) state_d = S_PIX_WR;
        else if (n_q == 3'd7) state_d = S_IDLE;
      end
      S_PIX_WR: begin
        state_d = (n_q == 3'd7) ? S_IDLE : S_PIX;
      end
      S_WALK: begin
        if (!walk_iss && !v1_q) state_d = S_MOD;
      end
      S_MOD: begin
        if (modv_q < per_eff) state_d = S_FIN;
      end
      S_FIN:      state_d = S_IDLE;
      S_PULL_RD:  state_d = S_PULL_DAT;
      S_PULL_DAT: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Handshake and store controls.
  always_comb begin
    in_stall_o = (state_q != S_IDLE) || out_vld_q;
    d_we = 1'b0; d_waddr = sweep_q; d_wdata = 8'h00;
    d_re = 1'b0; d_raddr = widx_q[ADDR_W-1:0];
    s_we = 1'b0; s_waddr = sweep_q; s_wdata = 8'h00;
    s_re = 1'b0; s_raddr = widx_q[ADDR_W-1:0];
    unique case (state_q)
      S_INIT: begin
        d_we = 1'b1;
        s_we = 1'b1;
      end
      S_CLEAR: begin
        d_we = 1'b1;
      end
      S_PIX: begin
        d_re    = px_do;
        d_raddr = px_idx[ADDR_W-1:0];
      end
      S_PIX_WR: begin
        d_we    = 1'b1;
        d_waddr = paddr_q;
        d_wdata = d_rdata | pmask_q;
      end
      S_WALK: begin
        d_re    = walk_iss;
        s_re    = walk_iss;
        s_we    = walk_diff;
        s_waddr = a1_q;
        s_wdata = d_rdata;
      end
      S_PULL_RD: begin
        s_re    = 1'b1;
        s_raddr = pidx_q;
      end
      default: ;
    endcase
  end

  vdwr_store u_draw (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  vdwr_store u_shadow (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd140;
      height_q <= 7'd32;
      upside_q <= 1'b0;
      invert_q <= 1'b0;
      period_q <= 8'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i[6:0];
        CFG_UPSIDE: upside_q <= cfg_data_i[0];
        CFG_INVERT: invert_q <= cfg_data_i[0];
        CFG_PERIOD: period_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer datapath and transfer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q       <= '0;
      rcount_q      <= '0;
      win_min_col_q <= '0;
      win_max_col_q <= '0;
      win_min_row_q <= '0;
      win_max_row_q <= '0;
      send_col_q    <= '0;
      send_row_q    <= '0;
      hdr_q         <= '0;
      busy_q        <= 1'b0;
      v1_q          <= 1'b0;
      n_q           <= '0;
      out_vld_q     <= 1'b0;
      pend_q        <= 1'b0;
    end else begin
      // Output register drains; the second brightness byte follows.
      if (out_acc) begin
        out_vld_q <= pend_q;
        if (pend_q) begin
          out_data_q <= 1'b1;
          out_byte_q <= {6'd0, pend_lvl_q};
          out_last_q <= 1'b1;
          pend_q     <= 1'b0;
        end
      end
      unique case (state_q)
        S_INIT, S_CLEAR: begin
          sweep_q <= sweep_q + ADDR_W'(1);
        end
        S_IDLE: begin
          sweep_q  <= '0;
          n_q      <= '0;
          wx_q     <= '0;
          wr_q     <= '0;
          widx_q   <= '0;
          v1_q     <= 1'b0;
          pidx_q   <= pull_idx[ADDR_W-1:0];
          prange_q <= pull_idx < IDX_W'(STORE_DEPTH);
          min_x_q  <= w_eff;
          max_x_q  <= '0;
          min_r_q  <= rows;
          max_r_q  <= '0;
          dirty_q  <= 1'b0;
          force_q  <= force_full_i;
          modv_q   <= {1'b0, rcount_q} + 9'd1;
          py_q     <= pos_y_i;
          if (mode_i == MODE_EIGHT) begin
            pbase_q <= COL_W'({pos_x_i[7:3], 3'b000});
            pbits_q <= pixel_bits_i;
          end else begin
            pbase_q <= COL_W'(pos_x_i);
            pbits_q <= 8'h80;
          end
          if (in_acc) begin
            case (mode_i)
              MODE_PULL: begin
                if (busy_q && hdr_q != HDR_DONE) begin
                  out_vld_q  <= 1'b1;
                  out_data_q <= hdr_q != 3'd0;
                  out_byte_q <= hdr_byte;
                  out_last_q <= 1'b0;
                  hdr_q      <= hdr_q + 3'd1;
                end
              end
              MODE_BRIGHT: begin
                out_vld_q  <= 1'b1;
                out_data_q <= 1'b0;
                out_byte_q <= BRIGHT_CMD;
                out_last_q <= 1'b0;
                pend_q     <= 1'b1;
                pend_lvl_q <= bright_code(percent_i);
              end
              default: ;
            endcase
          end
        end
        S_PIX: begin
          paddr_q <= px_idx[ADDR_W-1:0];
          pmask_q <= 8'h80 >> px_ym[2:0];
          if (!px_do) n_q <= n_q + 3'd1;
        end
        S_PIX_WR: begin
          n_q <= n_q + 3'd1;
        end
        S_WALK: begin
          // Issue stage: walk row by row, column by column.
          v1_q <= walk_iss;
          x1_q <= wx_q;
          r1_q <= wr_q;
          a1_q <= widx_q[ADDR_W-1:0];
          if (walk_iss) begin
            widx_q <= widx_q + (ADDR_W + 1)'(1);
            if (wx_q == w_m1) begin
              wx_q <= '0;
              wr_q <= wr_q + ROWS_W'(1);
            end else begin
              wx_q <= wx_q + COL_W'(1);
            end
          end
          // Compare stage: grow the changed box.
          if (walk_diff) begin
            dirty_q <= 1'b1;
            if (x1_q < min_x_q) min_x_q <= x1_q;
            if (x1_q > max_x_q) max_x_q <= x1_q;
            if (r1_q < min_r_q) min_r_q <= r1_q;
            if (r1_q + ROWS_W'(1) > max_r_q) max_r_q <= r1_q + ROWS_W'(1);
          end
        end
        S_MOD: begin
          if (modv_q >= per_eff) modv_q <= modv_q - per_eff;
        end
        S_FIN: begin
          rcount_q <= modv_q[7:0];
          if (force_q || modv_q[7:0] == 8'd0) begin
            rcount_q      <= '0;
            win_min_col_q <= '0;
            win_max_col_q <= w_m1[7:0];
            win_min_row_q <= '0;
            win_max_row_q <= rows;
            send_col_q    <= '0;
            send_row_q    <= '0;
            hdr_q         <= '0;
            busy_q        <= 1'b1;
          end else if (dirty_q) begin
            win_min_col_q <= min_x_q;
            win_max_col_q <= max_x_q[7:0];
            win_min_row_q <= min_r_q;
            win_max_row_q <= max_r_q;
            send_col_q    <= min_x_q[7:0];
            send_row_q    <= 4'(min_r_q);
            hdr_q         <= '0;
            busy_q        <= 1'b1;
          end
        end
        S_PULL_RD: ;
        S_PULL_DAT: begin
          out_vld_q  <= 1'b1;
          out_data_q <= 1'b1;
          out_byte_q <= (prange_q ? s_rdata : 8'h00) ^ {8{invert_q}};
          out_last_q <= pull_fin;
          if (pull_fin) begin
            busy_q <= 1'b0;
            hdr_q  <= '0;
          end else if (send_col_q >= win_max_col_q) begin
            send_col_q <= win_min_col_q[7:0];
            send_row_q <= send_row_q + 4'd1;
          end else begin
            send_col_q <= send_col_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign is_data_o   = out_data_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule
